@@ hw/rtl/tfir_pkg.sv @@
// Shared types and constants for the triangle range fold block.
// Used by triangle_fold_into_range; depends on nothing else.
package tfir_pkg;

  // Width of the phase word, the bounds and the folded result.
  localparam int unsigned DW = 32;
  // Width of the remainder and of the period (twice the span).
  localparam int unsigned RW = DW + 1;
  // Division stages, one remainder bit each, then the fold and the offset add.
  localparam int unsigned NS = DW + 2;

  typedef enum logic [0:0] {
    REG_LOWER = 1'b0,
    REG_UPPER = 1'b1
  } cfg_reg_e;

endpackage

@@ hw/rtl/triangle_fold_into_range.sv @@
// Triangle-wave fold of a phase word into a configured closed range.
// Fully pipelined remainder and fold; depends on tfir_pkg.
//
// Usage: the input channel (in_valid_i, in_stall_o, phase_i) takes one phase
// word per clock while in_stall_o is low. The output channel (out_valid_o,
// out_stall_i, folded_value_o) returns one folded word per input word, in order.
// The two bounds are written through cfg_we_i, cfg_idx_i and cfg_wdata_i
// while no word is in flight. Their order does not matter. The block uses
// the new bounds from the cycle after the write. There is one stage per
// remainder bit of the phase mod period division, then one stage for the
// fold and one for the offset add. Throughput is one word per cycle while
// the output is not stalled.
// Reset clears the bounds to zero and empties the pipeline.
// When the receiver stalls, each stage holds its word. Empty stages ahead of
// it keep filling, so in_stall_o rises only when every stage holds a word
// and the output is stalled.
module triangle_fold_into_range (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [tfir_pkg::DW-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [tfir_pkg::DW-1:0] phase_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [tfir_pkg::DW-1:0] folded_value_o
);
  import tfir_pkg::*;

  // Configuration and derived range.
  logic [DW-1:0] lower_q, lower_d, upper_q, upper_d;
  logic [DW-1:0] lo_q, lo_d, hi_d, span_q, span_d;
  logic [RW-1:0] period_w;
  logic          equal_w;

  always_comb begin
    lower_d = lower_q;
    upper_d = upper_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LOWER: lower_d = cfg_wdata_i;
        REG_UPPER: upper_d = cfg_wdata_i;
        default:   lower_d = lower_q;
      endcase
    end
    if (lower_d <= upper_d) begin
      lo_d = lower_d;
      hi_d = upper_d;
    end else begin
      lo_d = upper_d;
      hi_d = lower_d;
    end
    span_d = hi_d - lo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= '0;
      lo_q    <= '0;
      span_q  <= '0;
    end else begin
      lower_q <= lower_d;
      upper_q <= upper_d;
      lo_q    <= lo_d;
      span_q  <= span_d;
    end
  end

  assign period_w = {span_q, 1'b0};
  assign equal_w  = (span_q == '0);

  // Pipeline control: a stage loads when it is empty or its word moves on.
  logic [NS-1:0] vld_q;
  logic [NS:0]   rdy;

  assign rdy[NS] = !out_stall_i;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NS-1];

  // Restoring remainder stages, most significant phase bit first.
  logic [DW-1:0] x_q [DW];
  logic [RW-1:0] r_q [DW];

  for (genvar k = 0; k < DW; k++) begin : g_div
    logic          v_in;
    logic [DW-1:0] x_in;
    logic [RW-1:0] r_in;
    logic [RW:0]   rs;
    logic [RW-1:0] r_nxt;

    if (k == 0) begin : g_first
      assign v_in = in_valid_i;
      assign x_in = phase_i;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = vld_q[k-1];
      assign x_in = x_q[k-1];
      assign r_in = r_q[k-1];
    end

    always_comb begin
      rs = {r_in, x_in[DW-1-k]};
      if (rs >= {1'b0, period_w}) begin
        r_nxt = RW'(rs - {1'b0, period_w});
      end else begin
        r_nxt = rs[RW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        x_q[k] <= x_in;
        r_q[k] <= r_nxt;
      end
    end
  end

  // Fold stage: offset from the low bound on the rising or falling half.
  logic [DW-1:0] off_q, off_d;
  logic [RW-1:0] t_w;
  logic [RW-1:0] fall_w;

  assign t_w    = r_q[DW-1];
  assign fall_w = period_w - t_w;

  always_comb begin
    if (equal_w) begin
      off_d = '0;
    end else if (t_w <= {1'b0, span_q}) begin
      off_d = t_w[DW-1:0];
    end else begin
      off_d = fall_w[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[DW] <= 1'b0;
    end else if (rdy[DW]) begin
      vld_q[DW] <= vld_q[DW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[DW]) begin
      off_q <= off_d;
    end
  end

  // Output register.
  logic [DW-1:0] out_q, out_d;

  assign out_d = lo_q + off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[NS-1] <= 1'b0;
    end else if (rdy[NS-1]) begin
      vld_q[NS-1] <= vld_q[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      out_q <= out_d;
    end
  end

  assign folded_value_o = out_q;

`ifndef SYNTHESIS
  // The input side is held off only when every stage is full and the output waits.
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q) && out_stall_i)
    else $error("input stalled while the pipeline has room");

  // Words in flight change only by accepted inputs and delivered outputs.
  a_word_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      ($countones(vld_q) + $past(out_valid_o && !out_stall_i) ==
       $past($countones(vld_q)) + $past(in_valid_i && !in_stall_o)))
    else $error("word lost or duplicated in the pipeline");

  // The stored range never reaches past the top of the word.
  a_range_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, lo_q} + {1'b0, span_q}) <= {1'b0, {DW{1'b1}}})
    else $error("fold range exceeds the word width");

  // Equal bounds fold every phase to the low bound.
  a_equal_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (equal_w && rdy[DW]) |-> (off_d == '0))
    else $error("nonzero offset for equal bounds");
`endif

endmodule
